@@ rtl/mvs_pkg.sv @@
// Shared types and constants for the mean, variance and standard deviation block.
`timescale 1ns / 1ps
`default_nettype none
package mvs_pkg;

   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 5;
   localparam int KIND_W   = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_MEAN = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_DEV  = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_STD  = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_VAR  = KIND_W'(3);

   // operations of the shared divide / square root unit
   localparam logic OP_DIV  = 1'b0;
   localparam logic OP_SQRT = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } mvs_ctl_type;

   typedef struct packed {
      logic done;
      logic rem_nz;
   } mvs_sts_type;

endpackage
`default_nettype wire

@@ rtl/mvs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mvs_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/mvs_unit.sv @@
// Shared iterative unit: restoring divide (one quotient bit a cycle) and integer square root.
`timescale 1ns / 1ps
`default_nettype none
module mvs_unit #(
   parameter int UW = 42,
   parameter int DW = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  mvs_pkg::mvs_ctl_type ctl,
   input  logic [UW-1:0]       arg_a,
   input  logic [DW-1:0]       arg_b,
   output mvs_pkg::mvs_sts_type sts,
   output logic [UW-1:0]       result
);
   import mvs_pkg::*;

   localparam int HW  = UW / 2;
   localparam int RW  = (DW + 1 > HW + 2) ? DW + 1 : HW + 2;
   localparam int SCW = $clog2(UW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           op_ff, op_in;
   logic [SCW-1:0] cnt_ff, cnt_in;
   logic [UW-1:0]  x_ff, x_in;
   logic [DW-1:0]  dvs_ff, dvs_in;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [HW-1:0]  root_ff, root_in;

   logic [RW-1:0]  div_rem, sq_rem, sq_trial;
   logic           div_ge, sq_ge;

   always_comb begin
      div_rem  = {rem_ff[RW-2:0], x_ff[UW-1]};
      div_ge   = div_rem >= RW'(dvs_ff);
      sq_rem   = {rem_ff[RW-3:0], x_ff[UW-1:UW-2]};
      sq_trial = RW'({root_ff, 2'b01});
      sq_ge    = sq_rem >= sq_trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      root_in = root_ff;

      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         x_in    = arg_a;
         dvs_in  = arg_b;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = (ctl.op == OP_SQRT) ? SCW'(HW) : SCW'(UW);
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            rem_in = div_ge ? (div_rem - RW'(dvs_ff)) : div_rem;
            x_in   = {x_ff[UW-2:0], div_ge};
         end else begin
            rem_in  = sq_ge ? (sq_rem - sq_trial) : sq_rem;
            x_in    = {x_ff[UW-3:0], 2'b00};
            root_in = {root_ff[HW-2:0], sq_ge};
         end
         cnt_in = cnt_ff - SCW'(1);
         if (cnt_ff == SCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign result     = (op_ff == OP_SQRT) ? UW'(root_ff) : x_ff;
   assign sts.done   = done_ff;
   assign sts.rem_nz = |rem_ff;

endmodule
`default_nettype wire

@@ rtl/mean_variance_stddev.sv @@
// Top level: population mean, deviations, standard deviation and variance of Q8.8 samples.
//
// Requests carry one signed Q8.8 sample each and are taken one per cycle while
// the block is loading; each sample goes into a sample RAM of MAX_SAMPLES
// entries and into a running sum. Samples past capacity are dropped and the
// overflowed flag is raised on every result of that set. The request marked
// is_last closes the set: the block then stalls requests while it streams the
// RAM once to sum the squares, forms D = n*Q - S*S, runs the shared bit-serial
// unit for the mean divide and for D / n^2 (UW-bit dividend, UW = 30 +
// 2*ceil(log2(MAX_SAMPLES+1)), 42 at the default size) and for the square
// root, then emits the mean, one deviation per stored sample (a RAM read and
// an output load each), the standard deviation and the variance, which carries
// last_result. Results sit in an output register, so the next set may start
// loading while the variance waits. The RAM is only written while loading and
// only read while processing, so the two ports never touch the same entry in
// one cycle.
`timescale 1ns / 1ps
`default_nettype none
module mean_variance_stddev #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [mvs_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mvs_pkg::KIND_W-1:0]          rsp_kind,
   output logic [mvs_pkg::INDEX_W-1:0]         rsp_sample_index,
   output logic signed [mvs_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                rsp_overflowed,
   output logic                                rsp_last_result
);
   import mvs_pkg::*;

   // count, address and datapath widths
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SW   = SAMPLE_W + CW;          // running sum, signed
   localparam int SQ1W = 2 * SAMPLE_W - 1;       // one square
   localparam int SQW  = 2 * SAMPLE_W - 2 + CW;  // sum of squares
   localparam int UW   = 2 * SAMPLE_W - 2 + 2 * CW;
   localparam int DW   = 2 * CW;
   localparam int HW   = UW / 2;

   // sequencer states
   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_SQ    = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_DIFF  = 4'd3;
   localparam logic [3:0] S_MDIV  = 4'd4;
   localparam logic [3:0] S_MWAIT = 4'd5;
   localparam logic [3:0] S_VDIV  = 4'd6;
   localparam logic [3:0] S_VWAIT = 4'd7;
   localparam logic [3:0] S_SQRT  = 4'd8;
   localparam logic [3:0] S_SWAIT = 4'd9;
   localparam logic [3:0] S_OMEAN = 4'd10;
   localparam logic [3:0] S_DRD   = 4'd11;
   localparam logic [3:0] S_DOUT  = 4'd12;
   localparam logic [3:0] S_OSTD  = 4'd13;
   localparam logic [3:0] S_OVAR  = 4'd14;

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic                 drop_ff, drop_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 p1_ff, p1_in;
   logic                 p2_ff, p2_in;
   logic [SQ1W-1:0]      sqv_ff, sqv_in;
   logic [SQW-1:0]       qacc_ff, qacc_in;
   logic [SW-1:0]        sabs_ff, sabs_in;
   logic [UW-1:0]        nq_ff, nq_in;
   logic [UW-1:0]        ss_ff, ss_in;
   logic [UW-1:0]        d_ff, d_in;
   logic [DW-1:0]        nn_ff, nn_in;
   logic signed [SW-1:0] mean_ff, mean_in;
   logic [UW-1:0]        qv_ff, qv_in;
   logic [HW-1:0]        std_ff, std_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]           kind_ff, kind_in;
   logic [INDEX_W-1:0]          index_ff, index_in;
   logic signed [VALUE_W-1:0]   value_ff, value_in;
   logic                        ovf_ff, ovf_in;
   logic                        last_ff, last_in;

   logic                          req_accept;
   logic                          slot_free;
   logic                          out_load;
   logic [CW-1:0]                 n_eff;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic signed [SAMPLE_W-1:0]    rd_sample;
   logic signed [2*SAMPLE_W-1:0]  sq_prod;
   logic [UW:0]                   diff;
   logic signed [SW-1:0]          mq;
   mvs_ctl_type                   unit_ctl;
   mvs_sts_type                   unit_sts;
   logic [UW-1:0]                 unit_a;
   logic [DW-1:0]                 unit_b;
   logic [UW-1:0]                 unit_result;

   assign req_stall  = (state_ff != S_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign n_eff      = (count_ff == '0) ? CW'(1) : count_ff;

   // store while there is room
   assign ram_wr_en = req_accept && (count_ff < CW'(MAX_SAMPLES));
   assign ram_rd_en = ((state_ff == S_SQ) && (idx_ff < count_ff)) || (state_ff == S_DRD);

   mvs_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_sample)
   );

   mvs_unit #(
      .UW (UW),
      .DW (DW)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .arg_a  (unit_a),
      .arg_b  (unit_b),
      .sts    (unit_sts),
      .result (unit_result)
   );

   assign sq_prod = rd_sample * rd_sample;
   assign diff    = {1'b0, nq_ff} - {1'b0, ss_ff};
   assign mq      = signed'(unit_result[SW-1:0]);

   // launch the shared unit
   always_comb begin
      unit_ctl.start = (state_ff == S_MDIV) || (state_ff == S_VDIV) || (state_ff == S_SQRT);
      unit_ctl.op    = (state_ff == S_SQRT) ? OP_SQRT : OP_DIV;
      unit_b         = (state_ff == S_MDIV) ? DW'(n_eff) : nn_ff;
      case (state_ff)
         S_MDIV:  unit_a = UW'(sabs_ff);
         S_SQRT:  unit_a = qv_ff;
         default: unit_a = d_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      idx_in   = idx_ff;
      p1_in    = 1'b0;
      p2_in    = 1'b0;
      sqv_in   = sqv_ff;
      qacc_in  = qacc_ff;
      sabs_in  = sabs_ff;
      nq_in    = nq_ff;
      ss_in    = ss_ff;
      d_in     = d_ff;
      nn_in    = nn_ff;
      mean_in  = mean_ff;
      qv_in    = qv_ff;
      std_in   = std_ff;

      out_load = 1'b0;
      kind_in  = kind_ff;
      index_in = index_ff;
      value_in = value_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;

      unique case (state_ff)
         S_LOAD: begin
            // arm the square pass for the set being loaded
            idx_in  = '0;
            qacc_in = '0;
            if (req_accept) begin
               if (ram_wr_en) begin
                  count_in = count_ff + CW'(1);
                  sum_in   = sum_ff + SW'(req_sample);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_is_last) begin
                  state_in = S_SQ;
               end
            end
         end
         S_SQ: begin
            // stream the RAM: read, square, accumulate
            sabs_in = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
            if (ram_rd_en) begin
               idx_in = idx_ff + CW'(1);
               p1_in  = 1'b1;
            end
            p2_in = p1_ff;
            if (p1_ff) begin
               sqv_in = sq_prod[SQ1W-1:0];
            end
            if (p2_ff) begin
               qacc_in = qacc_ff + SQW'(sqv_ff);
            end
            if (!ram_rd_en && !p1_ff && !p2_ff) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            nq_in    = UW'(n_eff) * UW'(qacc_ff);
            ss_in    = UW'(sabs_ff) * UW'(sabs_ff);
            nn_in    = DW'(n_eff) * DW'(n_eff);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            // clamp to zero, as a negative difference cannot carry meaning
            d_in     = diff[UW] ? '0 : diff[UW-1:0];
            state_in = S_MDIV;
         end
         S_MDIV: begin
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (unit_sts.done) begin
               // floor toward minus infinity for a negative sum
               mean_in  = sum_ff[SW-1] ? (-mq - SW'(unit_sts.rem_nz)) : mq;
               state_in = S_VDIV;
            end
         end
         S_VDIV: begin
            state_in = S_VWAIT;
         end
         S_VWAIT: begin
            if (unit_sts.done) begin
               qv_in    = unit_result;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (unit_sts.done) begin
               std_in   = unit_result[HW-1:0];
               state_in = S_OMEAN;
            end
         end
         S_OMEAN: begin
            idx_in = '0;
            if (slot_free) begin
               out_load = 1'b1;
               kind_in  = KIND_MEAN;
               index_in = '0;
               value_in = VALUE_W'(mean_ff);
               ovf_in   = drop_ff;
               last_in  = 1'b0;
               state_in = (count_ff == '0) ? S_OSTD : S_DRD;
            end
         end
         S_DRD: begin
            state_in = S_DOUT;
         end
         S_DOUT: begin
            // read data holds until the output register frees up
            if (slot_free) begin
               out_load = 1'b1;
               kind_in  = KIND_DEV;
               index_in = INDEX_W'(idx_ff);
               value_in = VALUE_W'(mean_ff) - VALUE_W'(rd_sample);
               ovf_in   = drop_ff;
               last_in  = 1'b0;
               idx_in   = idx_ff + CW'(1);
               state_in = ((idx_ff + CW'(1)) == count_ff) ? S_OSTD : S_DRD;
            end
         end
         S_OSTD: begin
            if (slot_free) begin
               out_load = 1'b1;
               kind_in  = KIND_STD;
               index_in = '0;
               value_in = VALUE_W'(std_ff);
               ovf_in   = drop_ff;
               last_in  = 1'b0;
               state_in = S_OVAR;
            end
         end
         S_OVAR: begin
            if (slot_free) begin
               out_load = 1'b1;
               kind_in  = KIND_VAR;
               index_in = '0;
               value_in = VALUE_W'(qv_ff >> 8);
               ovf_in   = drop_ff;
               last_in  = 1'b1;
               // close the set and go back to loading
               count_in = '0;
               sum_in   = '0;
               drop_in  = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         drop_ff      <= drop_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      sqv_ff   <= sqv_in;
      qacc_ff  <= qacc_in;
      sabs_ff  <= sabs_in;
      nq_ff    <= nq_in;
      ss_ff    <= ss_in;
      d_ff     <= d_in;
      nn_ff    <= nn_in;
      mean_ff  <= mean_in;
      qv_ff    <= qv_in;
      std_ff   <= std_in;
      kind_ff  <= kind_in;
      index_ff <= index_in;
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
      last_ff  <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_sample_index = index_ff;
   assign rsp_value        = value_ff;
   assign rsp_overflowed   = ovf_ff;
   assign rsp_last_result  = last_ff;

`ifndef SYNTHESIS
   // the shared unit only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> (state_ff == S_MWAIT || state_ff == S_VWAIT || state_ff == S_SWAIT))
      else $error("arithmetic unit finished outside a wait state");

   // the fill count never passes the RAM depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("sample count beyond capacity");

   // only the variance closes a run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> (rsp_kind == KIND_VAR))
      else $error("last result flagged on a result other than the variance");

   // loading the variance empties the set
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OVAR && slot_free) |=> (state_ff == S_LOAD && count_ff == '0 && !drop_ff))
      else $error("set not cleared after the variance");
`endif

endmodule
`default_nettype wire
